### hdl/npl1_pkg.sv
`timescale 1ns / 1ps

package npl1_pkg;

	localparam int MAX_ANCHORS = 64;
	localparam int AIDX_W = $clog2(MAX_ANCHORS);
	localparam int ACNT_W = $clog2(MAX_ANCHORS + 1);
	localparam int COORD_BITS = 30;
	localparam int CNT_W = 24;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} bk_state_t;

	typedef struct packed {
		op_t                   kind;
		logic [COORD_BITS-1:0] position;
		logic [COORD_BITS-1:0] height;
	} item_t;

endpackage

### hdl/nearest_point_l1_range_count.sv
`timescale 1ns / 1ps

// Checks points against a table of up to 64 anchor positions on a line.
// An item (operation, position, height) is taken at a clock edge where start
// is high and busy is low; busy rises while the two-entry input queue is full.
// Operation 0 loads an anchor, 1 queries a point, 2 clears table and count.
// Every item gives exactly one result beat, marked by done for one cycle, with
// covered, total_covered and load_dropped; the receiver cannot hold it off.
// The user must write the range limit through cfg_we and cfg_wdata only while idle; the block has no check.
// Load, clear and short queries finish in the idle state without a scan, so
// they stream at one item per cycle unless a scanning query is ahead of
// them. A query that scans walks the anchor memory through its single read
// port, one entry per cycle; the scan stops at the first anchor in range.
// Reset empties the queue and clears the anchor count, the covered count and
// the range limit; the anchor memory itself is not cleared.
module nearest_point_l1_range_count_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [npl1_pkg::COORD_BITS-1:0] position,
	input  logic [npl1_pkg::COORD_BITS-1:0] height,
	input  logic                            cfg_we,
	input  logic [npl1_pkg::COORD_BITS-1:0] cfg_wdata,
	output logic                            done,
	output logic                            covered,
	output logic [npl1_pkg::CNT_W-1:0]      total_covered,
	output logic                            load_dropped
);

	logic [npl1_pkg::COORD_BITS-1:0] range_limit_q;
	logic                            q_valid;
	logic                            q_pop;
	npl1_pkg::item_t                 q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= '0;
		end else if (cfg_we) begin
			range_limit_q <= cfg_wdata;
		end
	end

	npl1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.position  (position),
		.height    (height),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	npl1_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.range_limit   (range_limit_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.done          (done),
		.covered       (covered),
		.total_covered (total_covered),
		.load_dropped  (load_dropped)
	);

	a_cov_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(covered && load_dropped))
		else $error("covered and load_dropped both set");

	a_cov_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && covered) |-> (total_covered != '0))
		else $error("covered beat with zero total");

	a_cov_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && covered && ($past(total_covered) != npl1_pkg::CNT_MAX)) |->
		(total_covered == npl1_pkg::CNT_W'($past(total_covered) + 1'b1)))
		else $error("total did not advance by one on a covered beat");

	a_total_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(total_covered))
		else $error("total changed without a result beat");

endmodule

### hdl/npl1_front.sv
`timescale 1ns / 1ps

module npl1_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [npl1_pkg::COORD_BITS-1:0] position,
	input  logic [npl1_pkg::COORD_BITS-1:0] height,
	output logic                            q_valid,
	output npl1_pkg::item_t                 q_item,
	input  logic                            q_pop
);

	npl1_pkg::item_t                    entries_q [npl1_pkg::QDEPTH];
	logic [npl1_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [npl1_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [npl1_pkg::QCNT_W-1:0]        cnt_q;
	logic                               push;
	npl1_pkg::item_t                    new_item;

	assign busy = (cnt_q == npl1_pkg::QCNT_W'(npl1_pkg::QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_item = entries_q[rd_ptr_q];

	always_comb begin
		new_item.kind = npl1_pkg::op_t'(operation);
		new_item.position = position;
		new_item.height = height;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/npl1_back.sv
`timescale 1ns / 1ps

module npl1_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [npl1_pkg::COORD_BITS-1:0] range_limit,
	input  logic                            q_valid,
	input  npl1_pkg::item_t                 q_item,
	output logic                            q_pop,
	output logic                            done,
	output logic                            covered,
	output logic [npl1_pkg::CNT_W-1:0]      total_covered,
	output logic                            load_dropped
);

	logic [npl1_pkg::COORD_BITS-1:0] mem [npl1_pkg::MAX_ANCHORS];

	npl1_pkg::bk_state_t              state_q, state_d;
	logic [npl1_pkg::ACNT_W-1:0]      anchor_cnt_q, anchor_cnt_d;
	logic [npl1_pkg::CNT_W-1:0]       cov_cnt_q, cov_cnt_d;
	logic [npl1_pkg::ACNT_W-1:0]      idx_q, idx_d;
	logic                             vld_q, vld_d;
	logic [npl1_pkg::COORD_BITS-1:0]  rd_data_q;
	logic [npl1_pkg::COORD_BITS-1:0]  px_q;
	logic [npl1_pkg::COORD_BITS-1:0]  lim_h_q;
	logic [npl1_pkg::COORD_BITS-1:0]  delta;
	logic                             hit;
	logic                             rd_en;
	logic                             wr_en;
	logic                             start_scan;
	logic                             fin;
	logic                             fin_cov;
	logic                             fin_drop;
	logic                             done_q;
	logic                             covered_q;
	logic                             dropped_q;

	assign delta = (rd_data_q >= px_q) ? (rd_data_q - px_q) : (px_q - rd_data_q);
	assign hit = vld_q && (delta <= lim_h_q);

	always_comb begin
		state_d = state_q;
		anchor_cnt_d = anchor_cnt_q;
		cov_cnt_d = cov_cnt_q;
		idx_d = idx_q;
		vld_d = 1'b0;
		q_pop = 1'b0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		start_scan = 1'b0;
		fin = 1'b0;
		fin_cov = 1'b0;
		fin_drop = 1'b0;
		case (state_q)
			npl1_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.kind)
						npl1_pkg::OP_LOAD: begin
							fin = 1'b1;
							if (anchor_cnt_q != npl1_pkg::ACNT_W'(npl1_pkg::MAX_ANCHORS)) begin
								wr_en = 1'b1;
								anchor_cnt_d = anchor_cnt_q + 1'b1;
							end else begin
								fin_drop = 1'b1;
							end
						end
						npl1_pkg::OP_QUERY: begin
							if ((anchor_cnt_q == '0) || (q_item.height > range_limit)) begin
								fin = 1'b1;
							end else begin
								start_scan = 1'b1;
								idx_d = '0;
								state_d = npl1_pkg::BK_SCAN;
							end
						end
						npl1_pkg::OP_CLEAR: begin
							fin = 1'b1;
							anchor_cnt_d = '0;
							cov_cnt_d = '0;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			npl1_pkg::BK_SCAN: begin
				if (hit) begin
					fin = 1'b1;
					fin_cov = 1'b1;
					if (cov_cnt_q != npl1_pkg::CNT_MAX) begin
						cov_cnt_d = cov_cnt_q + 1'b1;
					end
					state_d = npl1_pkg::BK_IDLE;
				end else if (idx_q != anchor_cnt_q) begin
					rd_en = 1'b1;
					idx_d = idx_q + 1'b1;
					vld_d = 1'b1;
				end else begin
					fin = 1'b1;
					state_d = npl1_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = npl1_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[anchor_cnt_q[npl1_pkg::AIDX_W-1:0]] <= q_item.position;
		end
		if (rd_en) begin
			rd_data_q <= mem[idx_q[npl1_pkg::AIDX_W-1:0]];
		end
		if (start_scan) begin
			px_q <= q_item.position;
			lim_h_q <= range_limit - q_item.height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npl1_pkg::BK_IDLE;
			anchor_cnt_q <= '0;
			cov_cnt_q <= '0;
			idx_q <= '0;
			vld_q <= 1'b0;
			done_q <= 1'b0;
			covered_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			anchor_cnt_q <= anchor_cnt_d;
			cov_cnt_q <= cov_cnt_d;
			idx_q <= idx_d;
			vld_q <= vld_d;
			done_q <= fin;
			covered_q <= fin_cov;
			dropped_q <= fin_drop;
		end
	end

	assign done = done_q;
	assign covered = covered_q;
	assign total_covered = cov_cnt_q;
	assign load_dropped = dropped_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	typedef logic [npl1_pkg::COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {npl1_pkg::COORD_BITS{1'b1}};
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                       covered;
		logic [npl1_pkg::CNT_W-1:0] total;
		logic                       dropped;
	} outcome_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [1:0]                 operation = npl1_pkg::OP_NONE;
	coord_t                     position = '0;
	coord_t                     height = '0;
	logic                       cfg_we = 1'b0;
	coord_t                     cfg_wdata = '0;
	logic                       done;
	logic                       covered;
	logic [npl1_pkg::CNT_W-1:0] total_covered;
	logic                       load_dropped;

	coord_t                     anchors[$];
	coord_t                     reach = '0;
	logic [npl1_pkg::CNT_W-1:0] hit_total = '0;
	outcome_t                   due_results[$];

	int errors = 0;
	int cycles = 0;
	int n_beats = 0;
	int n_queries = 0;
	int n_hits = 0;
	int n_drops = 0;
	int n_clears = 0;
	int n_limits = 0;
	bit steady = 1'b0;

	nearest_point_l1_range_count_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.height(height),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.covered(covered),
		.total_covered(total_covered),
		.load_dropped(load_dropped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, due_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic outcome_t predict_coverage(npl1_pkg::op_t op, coord_t p, coord_t h);
		outcome_t r;
		coord_t offset;
		logic [npl1_pkg::COORD_BITS:0] span;
		r = '0;
		case (op)
			npl1_pkg::OP_LOAD: begin
				if (anchors.size() < npl1_pkg::MAX_ANCHORS) begin
					anchors.insert(anchors.size(), p);
				end else begin
					r.dropped = 1'b1;
				end
			end
			npl1_pkg::OP_QUERY: begin
				if (h <= reach) begin
					foreach (anchors[i]) begin
						offset = (anchors[i] >= p) ? anchors[i] - p : p - anchors[i];
						span = offset + h;
						if (span <= reach)
							r.covered = 1'b1;
					end
				end
				if (r.covered && hit_total != npl1_pkg::CNT_MAX)
					hit_total = hit_total + 1'b1;
			end
			npl1_pkg::OP_CLEAR: begin
				anchors.delete();
				hit_total = '0;
			end
			default: ;
		endcase
		r.total = hit_total;
		return r;
	endfunction

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				errors = errors + 1;
				if (errors <= 10)
					$display({"Unexpected result beat at cycle %0d: ",
						"covered %0d total %0d dropped %0d"},
						cycles, covered, total_covered, load_dropped);
			end else begin
				want = due_results.pop_front();
				if (covered !== want.covered || total_covered !== want.total ||
						load_dropped !== want.dropped) begin
					errors = errors + 1;
					if (errors <= 10)
						$display({"Mismatch at cycle %0d: expected covered %0d total %0d ",
							"dropped %0d, got covered %0d total %0d dropped %0d"},
							cycles, want.covered, want.total, want.dropped,
							covered, total_covered, load_dropped);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic send_beat(npl1_pkg::op_t op, coord_t p, coord_t h);
		int gap;
		outcome_t r;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		position <= p;
		height <= h;
		do @(posedge clk); while (busy !== 1'b0);
		r = predict_coverage(op, p, h);
		due_results.insert(due_results.size(), r);
		n_beats++;
		if (op == npl1_pkg::OP_QUERY)
			n_queries++;
		if (r.covered)
			n_hits++;
		if (r.dropped)
			n_drops++;
		if (op == npl1_pkg::OP_CLEAR)
			n_clears++;
	endtask

	task automatic drain();
		start <= 1'b0;
		wait (due_results.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_range_limit(coord_t v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		reach = v;
		cfg_we <= 1'b0;
		n_limits++;
	endtask

	task automatic test_directed_edges();
		send_beat(npl1_pkg::OP_QUERY, COORD_MAX, COORD_MAX);
		send_beat(npl1_pkg::OP_NONE, COORD_MAX, COORD_MAX);
		send_beat(npl1_pkg::OP_LOAD, '0, COORD_MAX);
		send_beat(npl1_pkg::OP_LOAD, COORD_MAX, '0);
		send_beat(npl1_pkg::OP_QUERY, '0, '0);
		send_beat(npl1_pkg::OP_QUERY, COORD_MAX, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd1, '0);
		send_beat(npl1_pkg::OP_CLEAR, COORD_MAX, COORD_MAX);
		send_beat(npl1_pkg::OP_QUERY, '0, '0);
		set_range_limit(30'd100);
		send_beat(npl1_pkg::OP_LOAD, 30'd500, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd600, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd601, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd450, 30'd50);
		send_beat(npl1_pkg::OP_QUERY, 30'd450, 30'd51);
		send_beat(npl1_pkg::OP_QUERY, 30'd500, 30'd101);
		send_beat(npl1_pkg::OP_QUERY, 30'd400, '0);
		send_beat(npl1_pkg::OP_NONE, 30'd500, '0);
		send_beat(npl1_pkg::OP_CLEAR, '0, '0);
		set_range_limit(COORD_MAX);
		send_beat(npl1_pkg::OP_LOAD, '0, '0);
		send_beat(npl1_pkg::OP_QUERY, COORD_MAX, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd5, COORD_MAX);
		send_beat(npl1_pkg::OP_QUERY, '0, COORD_MAX);
	endtask

	task automatic test_full_table();
		coord_t v;
		set_range_limit(30'd1000);
		send_beat(npl1_pkg::OP_CLEAR, '0, '0);
		repeat (npl1_pkg::MAX_ANCHORS) begin
			v = coord_t'($urandom());
			send_beat(npl1_pkg::OP_LOAD, v, coord_t'($urandom()));
		end
		repeat (4) send_beat(npl1_pkg::OP_LOAD, coord_t'($urandom()), coord_t'($urandom()));
		send_beat(npl1_pkg::OP_QUERY, anchors[0], '0);
		send_beat(npl1_pkg::OP_QUERY, anchors[npl1_pkg::MAX_ANCHORS-1] + 30'd1000, '0);
		send_beat(npl1_pkg::OP_QUERY, anchors[npl1_pkg::MAX_ANCHORS/2], 30'd1001);
		send_beat(npl1_pkg::OP_CLEAR, '0, '0);
		send_beat(npl1_pkg::OP_LOAD, 30'd77, '0);
		send_beat(npl1_pkg::OP_QUERY, 30'd77, 30'd1000);
	endtask

	task automatic send_near_query();
		int unsigned a, d, h, p, mode;
		a = 32'(anchors[$urandom_range(anchors.size() - 1)]);
		d = $urandom_range(32'(reach));
		mode = $urandom_range(99);
		if (mode < 60)
			h = $urandom_range(32'(reach) - d);
		else if (mode < 75)
			h = 32'(reach) - d;
		else if (mode < 90)
			h = 32'(reach) - d + 1;
		else
			h = $urandom() & 32'(COORD_MAX);
		if (h > 32'(COORD_MAX))
			h = $urandom() & 32'(COORD_MAX);
		if (a >= d && (a + d > 32'(COORD_MAX) || $urandom_range(1)))
			p = a - d;
		else if (a + d <= 32'(COORD_MAX))
			p = a + d;
		else
			p = $urandom() & 32'(COORD_MAX);
		send_beat(npl1_pkg::OP_QUERY, coord_t'(p), coord_t'(h));
	endtask

	task automatic test_random_phase(int n_items, coord_t limit, int load_pct);
		int r;
		coord_t base;
		set_range_limit(limit);
		steady = $urandom_range(3) == 0;
		base = coord_t'($urandom());
		repeat (n_items) begin
			r = $urandom_range(99);
			if (anchors.size() == 0 || r < load_pct) begin
				if ($urandom_range(1))
					send_beat(npl1_pkg::OP_LOAD,
						coord_t'(32'(base) + $urandom_range(2 * 32'(limit) + 64)),
						coord_t'($urandom()));
				else
					send_beat(npl1_pkg::OP_LOAD, coord_t'($urandom()), coord_t'($urandom()));
			end else if (r < 88) begin
				send_near_query();
			end else if (r < 91) begin
				send_beat(npl1_pkg::OP_CLEAR, coord_t'($urandom()), coord_t'($urandom()));
			end else if (r < 94) begin
				send_beat(npl1_pkg::OP_NONE, coord_t'($urandom()), coord_t'($urandom()));
			end else begin
				send_beat(npl1_pkg::OP_QUERY, coord_t'($urandom()), coord_t'($urandom()));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_table();
		test_random_phase(140, coord_t'($urandom_range(255)), 25);
		test_random_phase(140, coord_t'($urandom()), 30);
		test_random_phase(130, '0, 40);
		test_random_phase(130, COORD_MAX, 20);
		test_random_phase(110, coord_t'($urandom_range(4095)), 60);
		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d beats under %0d range limits: %0d queries, %0d covered.",
			n_beats, n_limits, n_queries, n_hits);
		$display("Loads dropped on a full table: %0d, clears: %0d, mismatches: %0d.",
			n_drops, n_clears, errors);
		if (errors == 0 && due_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
hdl/npl1_pkg.sv
hdl/npl1_front.sv
hdl/npl1_back.sv
hdl/nearest_point_l1_range_count.sv
sim/tb_top.sv
